[rtl/rms_of_samples_assert.svh]
// ----------------------------------------------------------------------------
// rms_of_samples_assert.svh
// assertion macros shared by the rms block modules
// ----------------------------------------------------------------------------
`ifndef RMS_OF_SAMPLES_ASSERT_SVH
`define RMS_OF_SAMPLES_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RMS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rms assertion failed");

// next-cycle implication, checked out of reset
`define RMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rms assertion failed");

`endif

[rtl/rms_pkg.sv]
// ----------------------------------------------------------------------------
// rms_pkg
// shared constants and controller/datapath interface types
// ----------------------------------------------------------------------------
package rms_pkg;

    localparam int MAX_COUNT   = 128;
    localparam int SAMPLE_W    = 16;
    localparam int SQUARE_W    = 2 * SAMPLE_W;
    localparam int CNT_W       = $clog2(MAX_COUNT + 1);
    // max sum is MAX_COUNT * 2^30, below 2^(30 + CNT_W)
    localparam int SUM_W       = SQUARE_W - 2 + CNT_W;
    localparam int ROOT_W      = SAMPLE_W;
    localparam int RAD_W       = 2 * ROOT_W;
    localparam int SQREM_W     = ROOT_W + 1;
    localparam int DIV_STEPS   = SUM_W;
    localparam int ROOT_STEPS  = ROOT_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;     // input transaction taken this cycle
        logic calc_clear; // clear divider and root remainders
        logic div_step;   // one restoring division step
        logic root_step;  // one square root digit
        logic load_out;   // move result to output register, clear set
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic out_free;   // output register can take a result this cycle
    } t_status;

endpackage

[rtl/rms_ctrl.sv]
// ----------------------------------------------------------------------------
// rms_ctrl
// sequencer: accumulate, divide, square root, hand off result
// ----------------------------------------------------------------------------
`include "rms_of_samples_assert.svh"

module rms_ctrl import rms_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_last,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_ACCUM    = 5'b00001,
        S_ADD_LAST = 5'b00010,
        S_DIVIDE   = 5'b00100,
        S_ROOT     = 5'b01000,
        S_HOLD     = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                accept;

    assign o_in_ready = (r_state == S_ACCUM);
    assign accept     = o_in_ready && i_in_valid;

    always_comb begin
        n_state          = r_state;
        n_step           = r_step;
        o_cmd            = '0;
        o_cmd.accept     = accept;
        case (r_state)
            S_ACCUM: begin
                if (accept && i_in_last) begin
                    n_state = S_ADD_LAST;
                end
            end
            S_ADD_LAST: begin
                // last square lands in the sum this cycle
                o_cmd.calc_clear = 1'b1;
                n_step           = '0;
                n_state          = S_DIVIDE;
            end
            S_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_step  = '0;
                    n_state = S_ROOT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (r_step == STEP_W'(ROOT_STEPS - 1)) begin
                    n_step  = '0;
                    n_state = S_HOLD;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_HOLD: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_ACCUM;
                end
            end
            default: begin
                n_state = S_ACCUM;
                n_step  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACCUM;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    `RMS_ASSERT_NEXT(a_div_to_root, i_clk, i_rst_n,
        r_state == S_DIVIDE && r_step == STEP_W'(DIV_STEPS - 1), r_state == S_ROOT)
    `RMS_ASSERT_NEXT(a_last_stops_input, i_clk, i_rst_n,
        accept && i_in_last, !o_in_ready)

endmodule

[rtl/rms_dp.sv]
// ----------------------------------------------------------------------------
// rms_dp
// square-accumulate, shift-subtract divider, digit square root, output reg
// ----------------------------------------------------------------------------
`include "rms_of_samples_assert.svh"

module rms_dp import rms_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    input  logic [SAMPLE_W-1:0]  i_sample,
    input  logic                 i_out_ready,
    output t_status              o_status,
    output logic                 o_out_valid,
    output logic [ROOT_W-1:0]    o_rms,
    output logic [CNT_W-1:0]     o_total,
    output logic                 o_overflowed
);

    logic [SUM_W-1:0]    r_sum;
    logic [CNT_W-1:0]    r_count;
    logic                r_drop;
    logic [SQUARE_W-1:0] r_square;
    logic                r_sq_add;
    logic [CNT_W-1:0]    r_div_rem;
    logic [SQREM_W-1:0]  r_sq_rem;
    logic [ROOT_W-1:0]   r_root;
    logic                r_out_valid;
    logic [ROOT_W-1:0]   r_rms;
    logic [CNT_W-1:0]    r_total;
    logic                r_ovf;

    logic [SAMPLE_W-1:0] mag;
    logic                room;
    logic [CNT_W:0]      div_sh;
    logic [CNT_W:0]      div_diff;
    logic                div_ge;
    logic [SQREM_W+1:0]  rt_sh;
    logic [SQREM_W+1:0]  rt_trial;
    logic                rt_ge;

    // magnitude; most negative sample gives 2^15 as unsigned
    assign mag  = i_sample[SAMPLE_W-1] ? (~i_sample + 1'b1) : i_sample;
    assign room = (r_count < CNT_W'(MAX_COUNT));

    assign div_sh   = {r_div_rem, r_sum[SUM_W-1]};
    assign div_diff = div_sh - {1'b0, r_count};
    assign div_ge   = (div_sh >= {1'b0, r_count});

    assign rt_sh    = {r_sq_rem, r_sum[RAD_W-1:RAD_W-2]};
    assign rt_trial = {1'b0, r_root, 2'b01};
    assign rt_ge    = (rt_sh >= rt_trial);

    assign o_status.out_free = !r_out_valid || i_out_ready;

    // sample intake: square is registered, added to the sum in the next cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && room) begin
            r_square <= mag * mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_drop   <= 1'b0;
            r_sq_add <= 1'b0;
        end else begin
            r_sq_add <= i_cmd.accept && room;
            if (i_cmd.load_out) begin
                r_count <= '0;
                r_drop  <= 1'b0;
            end else if (i_cmd.accept) begin
                if (room) begin
                    r_count <= r_count + 1'b1;
                end else begin
                    r_drop <= 1'b1;
                end
            end
        end
    end

    // sum register doubles as dividend/quotient and radicand shifter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_cmd.load_out) begin
            r_sum <= '0;
        end else if (i_cmd.div_step) begin
            r_sum <= {r_sum[SUM_W-2:0], div_ge};
        end else if (i_cmd.root_step) begin
            r_sum <= {r_sum[SUM_W-1:RAD_W], r_sum[RAD_W-3:0], 2'b00};
        end else if (r_sq_add) begin
            r_sum <= r_sum + SUM_W'(r_square);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_clear) begin
            r_div_rem <= '0;
            r_sq_rem  <= '0;
            r_root    <= '0;
        end else begin
            if (i_cmd.div_step) begin
                r_div_rem <= div_ge ? div_diff[CNT_W-1:0] : div_sh[CNT_W-1:0];
            end
            if (i_cmd.root_step) begin
                r_sq_rem <= rt_ge ? SQREM_W'(rt_sh - rt_trial) : SQREM_W'(rt_sh);
                r_root   <= {r_root[ROOT_W-2:0], rt_ge};
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_rms   <= r_root;
            r_total <= r_count;
            r_ovf   <= r_drop;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_rms        = r_rms;
    assign o_total      = r_total;
    assign o_overflowed = r_ovf;

    `RMS_ASSERT_NOW(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_COUNT))
    `RMS_ASSERT_NOW(a_drop_full, i_clk, i_rst_n, r_drop, r_count == CNT_W'(MAX_COUNT))
    `RMS_ASSERT_NOW(a_mean_fits, i_clk, i_rst_n, i_cmd.root_step,
        r_sum[SUM_W-1:RAD_W] == '0)
    `RMS_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, i_cmd.load_out,
        !r_out_valid || i_out_ready)

endmodule

[rtl/rms_of_samples.sv]
// ----------------------------------------------------------------------------
// rms_of_samples
// root mean square of signed q8.8 sample sets, result in unsigned q8.8
// ----------------------------------------------------------------------------
// usage:
//   input stream carries one signed q8.8 sample per transaction, tlast marks
//   the final sample of a set. non-last samples are taken one per cycle.
//   output stream carries one transaction per set: floor rms, the number of
//   samples used and an overflow flag (set when samples beyond 128 were
//   dropped; a dropped last sample still closes the set).
// set processing:
//   after the last sample the input is held off while the block adds the
//   final square, runs the bit-serial divider and the digit-by-digit square
//   root, then loads the output register once it is free.
//   the result shows on the output the cycle after that load.
// reset:
//   synchronous, active low; clears the running sum, count, overflow flag,
//   the sequencer and the output valid.
// stall:
//   the output register holds a finished result while the receiver stalls;
//   accumulation of the next set goes on meanwhile. only a second result
//   ready before the first is taken waits, with the input held off.
// ----------------------------------------------------------------------------
module rms_of_samples import rms_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] sample
    input  logic                   s_axis_tlast,   // last sample of the set
    // output stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [15:0] rms, [23:16] sample_total
    output logic                   m_axis_tuser    // [0] overflowed
);

    t_cmd                cmd;
    t_status             status;
    logic [ROOT_W-1:0]   rms;
    logic [CNT_W-1:0]    total;

    // sequencer; only commands and status cross to the datapath
    rms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .i_status   (status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    // accumulate, divide, root and output register
    rms_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_sample     (s_axis_tdata[SAMPLE_W-1:0]),
        .i_out_ready  (m_axis_tready),
        .o_status     (status),
        .o_out_valid  (m_axis_tvalid),
        .o_rms        (rms),
        .o_total      (total),
        .o_overflowed (m_axis_tuser)
    );

    // pack result fields, lowest field in lowest bits; count field is 8 bits
    assign m_axis_tdata = {8'(total), rms};

endmodule

[verif/rms_of_samples_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rms_of_samples_checker
// watches both streams, predicts each set's rms and compares the results
// ----------------------------------------------------------------------------
module rms_of_samples_checker import rms_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_tvalid,
    input  logic                   i_in_tready,
    input  logic [IN_TDATA_W-1:0]  i_in_tdata,   // [15:0] sample
    input  logic                   i_in_tlast,   // last sample of the set
    input  logic                   i_out_tvalid,
    input  logic                   i_out_tready,
    input  logic [OUT_TDATA_W-1:0] i_out_tdata,  // [15:0] rms, [23:16] sample_total
    input  logic                   i_out_tuser,  // [0] overflowed
    output int                     o_pending,
    output int                     o_errors
);

    typedef struct packed {
        logic [15:0] rms;
        logic [7:0]  total;
        logic        overflowed;
    } t_rms_result;

    t_rms_result rms_expected[$];
    logic [63:0] square_acc;
    int unsigned held_count;
    logic        dropped;
    int          mismatches = 0;

    // floor square root, one bit at a time from the top
    function automatic logic [63:0] floor_root(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] trial;
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = r | (64'd1 << b);
            if (trial * trial <= v) r = trial;
        end
        return r;
    endfunction

    task automatic take_sample(input logic [15:0] smp, input logic lst);
        logic [16:0]  mag;
        logic [63:0]  mean;
        t_rms_result  res;
        mag = smp[15] ? (17'h10000 - {1'b0, smp}) : {1'b0, smp};
        if (held_count < MAX_COUNT) begin
            square_acc = square_acc + 64'(mag) * 64'(mag);
            held_count++;
        end else begin
            dropped = 1'b1;
        end
        if (lst) begin
            mean = (held_count != 0) ? square_acc / 64'(held_count) : '0;
            res.rms        = 16'(floor_root(mean));
            res.total      = 8'(held_count);
            res.overflowed = dropped;
            rms_expected.push_back(res);
            square_acc = '0;
            held_count = 0;
            dropped    = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_rms_result got;
        t_rms_result want;
        if (!i_rst_n) begin
            square_acc = '0;
            held_count = 0;
            dropped    = 1'b0;
            rms_expected.delete();
        end else begin
            // results first, so a set closing on this edge cannot match itself
            if (i_out_tvalid && i_out_tready) begin
                got = {i_out_tdata[15:0], i_out_tdata[23:16], i_out_tuser};
                if (rms_expected.size() == 0) begin
                    $error("unexpected result: rms %0d, sample_total %0d, overflowed %0d",
                           got.rms, got.total, got.overflowed);
                    mismatches++;
                end else begin
                    want = rms_expected.pop_front();
                    if (got.rms != want.rms) begin
                        $error("rms: expected %0d, actual %0d", want.rms, got.rms);
                        mismatches++;
                    end
                    if (got.total != want.total) begin
                        $error("sample_total: expected %0d, actual %0d",
                               want.total, got.total);
                        mismatches++;
                    end
                    if (got.overflowed != want.overflowed) begin
                        $error("overflowed: expected %0d, actual %0d",
                               want.overflowed, got.overflowed);
                        mismatches++;
                    end
                end
            end
            if (i_in_tvalid && i_in_tready) take_sample(i_in_tdata[15:0], i_in_tlast);
        end
        o_pending <= rms_expected.size();
        o_errors  <= mismatches;
    end

endmodule

[verif/rms_of_samples_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rms_of_samples_test
// streams signed q8.8 sample sets into the rms block and checks each result
// against a predicted rms, sample count and overflow flag; covers extreme
// samples, full and overflowing sets, random stalls on both streams, a long
// output hold-off and a drained pause of the input
// ----------------------------------------------------------------------------
module rms_of_samples_test;
    import rms_pkg::*;

    localparam int RANDOM_ITEMS   = 600;
    localparam int QUIET_ITEMS    = 90;    // final stretch with no idling
    localparam int IDLE_LIMIT     = 4000;  // cycles with no transaction at all
    localparam int RX_HOLD_CYCLES = 300;   // long output hold-off
    localparam int DRAIN_CYCLES   = 120;   // longer than a set takes to finish
    localparam int FULL_SET_NO    = 2;     // exactly MAX_COUNT samples
    localparam int OVER_SET_NO    = 5;     // one sample too many, the last dropped
    localparam int WIDE_SET_NO    = 9;     // several dropped, most negative samples
    localparam int HOLD_SET_NO    = 3;     // receiver goes quiet here
    localparam int PAUSE_SET_NO   = 7;     // sender waits for every result here

    // how the samples of one set are picked
    typedef enum int {
        MIX_FULL,
        MIX_EXTREME,
        MIX_SMALL,
        MIX_MOST_NEG
    } t_mix;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [15:0] sample
    logic                   s_axis_tlast;   // last sample of the set
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [15:0] rms, [23:16] sample_total
    logic                   m_axis_tuser;   // [0] overflowed

    int   pending;
    int   errors;
    int   items_sent;
    int   idle_cycles = 0;
    logic idle_on;
    logic rx_hold_req;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    rms_of_samples u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    rms_of_samples_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_tvalid  (s_axis_tvalid),
        .i_in_tready  (s_axis_tready),
        .i_in_tdata   (s_axis_tdata),
        .i_in_tlast   (s_axis_tlast),
        .i_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .i_out_tdata  (m_axis_tdata),
        .i_out_tuser  (m_axis_tuser),
        .o_pending    (pending),
        .o_errors     (errors)
    );

    // one sample transaction, with an occasional idle burst ahead of it
    task automatic send_item(input logic [15:0] smp, input logic lst);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tlast  <= lst;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    function automatic logic [15:0] pick_sample(input t_mix mix);
        case (mix)
            MIX_EXTREME: begin
                case ($urandom_range(0, 4))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'h8001;
                    3:       return 16'h0000;
                    default: return 16'($urandom);
                endcase
            end
            MIX_SMALL:    return 16'($urandom_range(0, 64)) - 16'd32;
            MIX_MOST_NEG: return ($urandom_range(0, 7) != 0) ? 16'h8000 : 16'($urandom);
            default:      return 16'($urandom);
        endcase
    endfunction

    // a whole set, tlast on its final sample
    task automatic send_set(input int len, input t_mix mix);
        for (int k = 0; k < len; k++) send_item(pick_sample(mix), k == len - 1);
    endtask

    // wait with the input quiet until every predicted result has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // stimulus and verdict
    initial begin : stimulus
        int   set_no;
        int   set_len;
        t_mix mix;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        idle_on       <= 1'b1;
        rx_hold_req   <= 1'b0;
        items_sent    = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: single-sample sets at the extremes
        send_item(16'h0000, 1'b1);
        send_item(16'h8000, 1'b1);   // most negative squares to 2^30, rms 32768
        send_item(16'h7FFF, 1'b1);
        send_item(16'h0001, 1'b1);
        send_item(16'hFFFF, 1'b1);
        // mixed signs of one magnitude
        send_item(16'h0100, 1'b0);
        send_item(16'hFF00, 1'b0);
        send_item(16'h0100, 1'b0);
        send_item(16'hFF00, 1'b1);
        // both extremes in one set
        send_item(16'h7FFF, 1'b0);
        send_item(16'h8000, 1'b1);
        // alternating bit patterns
        send_item(16'h5555, 1'b0);
        send_item(16'hAAAA, 1'b1);
        // mean truncates before the root
        send_item(16'h0000, 1'b0);
        send_item(16'h0000, 1'b0);
        send_item(16'h0000, 1'b0);
        send_item(16'h0003, 1'b1);

        // random sets, mostly short, with a few full and overflowing ones
        items_sent = 0;
        set_no     = 0;
        while (items_sent < RANDOM_ITEMS) begin
            mix = t_mix'($urandom_range(0, 3));
            case (set_no)
                FULL_SET_NO: set_len = MAX_COUNT;
                OVER_SET_NO: set_len = MAX_COUNT + 1;
                WIDE_SET_NO: begin
                    set_len = MAX_COUNT + 7;
                    mix     = MIX_MOST_NEG;
                end
                default: begin
                    if ($urandom_range(0, 29) == 0)
                        set_len = $urandom_range(MAX_COUNT - 4, MAX_COUNT + 6);
                    else
                        set_len = $urandom_range(1, 8);
                end
            endcase
            // receiver stops taking results while short sets keep coming,
            // so the output register fills and the input stalls
            if (set_no == HOLD_SET_NO) rx_hold_req <= 1'b1;
            if (set_no == PAUSE_SET_NO) drain_results();
            if (items_sent >= RANDOM_ITEMS - QUIET_ITEMS) idle_on <= 1'b0;
            send_set(set_len, mix);
            set_no++;
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("rms_of_samples_test passed");
        end else begin
            $display("rms_of_samples_test failed");
        end
        $finish;
    end

    // output side: random stall bursts, one long hold-off on request
    initial begin : sink
        bit hold_done;
        hold_done = 1'b0;
        m_axis_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (rx_hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // watchdog: cycles in a row with no transaction on either stream
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog
        wait (idle_cycles >= IDLE_LIMIT);
        $display("rms_of_samples_test failed");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/rms_pkg.sv
rtl/rms_ctrl.sv
rtl/rms_dp.sv
rtl/rms_of_samples.sv
verif/rms_of_samples_checker.sv
verif/rms_of_samples_test.sv
